### src/ihc_pkg.sv
// Shared constants, types and tables for the RGB to intensity/chroma/hue converter.
`timescale 1ns / 1ps

package ihc_pkg;

  // Default channel code width.
  localparam int unsigned CHANNEL_BITS_DEF = 8;

  // Result field widths.
  localparam int unsigned INTEN_W  = 16;
  localparam int unsigned CHROMA_W = 16;
  localparam int unsigned HUE_W    = 15;

  // CORDIC angle accumulator, in units of 1e-9 degree.
  localparam int unsigned ZW           = 40;
  localparam int unsigned CORDIC_STEPS = 32;
  localparam int unsigned Q_FRAC       = 30;

  localparam logic signed [31:0]   SQRT3_Q30   = 32'sd1859775393;
  localparam logic signed [ZW-1:0] Z_180       = 40'sd180000000000;
  // Half of a 1/64 degree step, alone or together with a full turn.
  localparam logic signed [ZW-1:0] Z_ROUND     = 40'sd7812500;
  localparam logic signed [ZW-1:0] Z_WRAP_BIAS = 40'sd360007812500;

  // Chroma radicand is the squared-difference sum scaled by 2^15.
  localparam int unsigned RAD_SHIFT = 15;

  // floor(n/3) == (n * RECIP_3) >> 33 for every n below 2^32.
  localparam logic [31:0] RECIP_3       = 32'hAAAAAAAB;
  localparam int unsigned RECIP_3_SHIFT = 33;

  // Hue quantization: n = floor(B / HUE_DIV) with B = (angle + round) / 8.
  localparam int unsigned BW              = 36;
  localparam int unsigned T_SHIFT         = 3;
  localparam int unsigned HUE_PRE_SHIFT   = 10;
  localparam int unsigned HUE_RECIP_W     = 20;
  localparam logic [20:0] HUE_DIV         = 21'd1953125;
  localparam logic [HUE_RECIP_W-1:0] HUE_RECIP = 20'd562949;
  localparam int unsigned HUE_RECIP_SHIFT = 30;
  localparam logic [HUE_W-1:0] HUE_STEPS  = 15'd23040;

  typedef struct packed {
    logic valid;
    logic gray;
  } ihc_ctl_t;

  typedef struct packed {
    logic [INTEN_W-1:0]  intensity;
    logic [CHROMA_W-1:0] chroma;
    logic [HUE_W-1:0]    hue;
    logic                hue_undefined;
  } ihc_res_t;

  // atan(2^-i) in units of 1e-9 degree.
  function automatic logic signed [ZW-1:0] atan_ndeg(input int unsigned idx);
    logic signed [ZW-1:0] a;
    case (idx)
      0:  a = 40'sd45000000000;
      1:  a = 40'sd26565051177;
      2:  a = 40'sd14036243468;
      3:  a = 40'sd7125016349;
      4:  a = 40'sd3576334375;
      5:  a = 40'sd1789910608;
      6:  a = 40'sd895173710;
      7:  a = 40'sd447614171;
      8:  a = 40'sd223810500;
      9:  a = 40'sd111905677;
      10: a = 40'sd55952892;
      11: a = 40'sd27976453;
      12: a = 40'sd13988227;
      13: a = 40'sd6994114;
      14: a = 40'sd3497057;
      15: a = 40'sd1748528;
      16: a = 40'sd874264;
      17: a = 40'sd437132;
      18: a = 40'sd218566;
      19: a = 40'sd109283;
      20: a = 40'sd54642;
      21: a = 40'sd27321;
      22: a = 40'sd13660;
      23: a = 40'sd6830;
      24: a = 40'sd3415;
      25: a = 40'sd1708;
      26: a = 40'sd854;
      27: a = 40'sd427;
      28: a = 40'sd213;
      29: a = 40'sd107;
      30: a = 40'sd53;
      31: a = 40'sd27;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

### src/ihc_pix_if.sv
// Pixel input channel: valid/ready handshake with three channel codes.
`timescale 1ns / 1ps

interface ihc_pix_if #(
  parameter int unsigned CHANNEL_BITS = ihc_pkg::CHANNEL_BITS_DEF
) ();
  logic                    valid;
  logic                    ready;
  logic [CHANNEL_BITS-1:0] red;
  logic [CHANNEL_BITS-1:0] green;
  logic [CHANNEL_BITS-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

### src/ihc_res_if.sv
// Result channel: valid/ready handshake with intensity, chroma, hue and gray flag.
`timescale 1ns / 1ps

interface ihc_res_if ();
  logic                         valid;
  logic                         ready;
  logic [ihc_pkg::INTEN_W-1:0]  intensity;
  logic [ihc_pkg::CHROMA_W-1:0] chroma;
  logic [ihc_pkg::HUE_W-1:0]    hue;
  logic                         hue_undefined;

  modport source (output valid, output intensity, output chroma, output hue,
                  output hue_undefined, input ready);
  modport sink   (input valid, input intensity, input chroma, input hue,
                  input hue_undefined, output ready);
endinterface

### src/rgb_to_intensity_chroma_hue_core.sv
// Top level of the RGB to intensity/chroma/hue converter.
//
//   Channel | Direction | Handshake     | Payload
//   pix_i   | in        | valid / ready | red, green, blue (CHANNEL_BITS each)
//   res_o   | out       | valid / ready | intensity, chroma, hue, hue_undefined
//
// One pixel is taken every cycle while the skid register is empty.
// A result passes through the 32-cell chain, where each cell does one CORDIC
// rotation and the first CHANNEL_BITS+8 cells also one square-root digit, plus
// three front stages, four back stages and the output register.
// Reset clears only the valid and gray control bits; the pipeline needs no warm-up.
// A stalled output parks one result in a skid register, and the whole
// pipeline then holds until it drains.
`timescale 1ns / 1ps

module rgb_to_intensity_chroma_hue_core #(
  parameter int unsigned CHANNEL_BITS = ihc_pkg::CHANNEL_BITS_DEF
) (
  input logic       clk_i,
  input logic       rst_ni,
  ihc_pix_if.sink   pix_i,
  ihc_res_if.source res_o
);
  import ihc_pkg::*;

  localparam int unsigned XW = CHANNEL_BITS + 34;
  localparam int unsigned RB = CHANNEL_BITS + 8;
  localparam int unsigned XB = 2 * RB;
  localparam int unsigned NC = CORDIC_STEPS;

  logic                 en;
  ihc_ctl_t             c_ctl   [0:NC];
  logic [INTEN_W-1:0]   c_inten [0:NC];
  logic signed [XW-1:0] c_x     [0:NC];
  logic signed [XW-1:0] c_y     [0:NC];
  logic signed [ZW-1:0] c_z     [0:NC];
  logic [XB-1:0]        c_rad   [0:NC];
  logic [RB:0]          c_rem   [0:NC];
  logic [RB-1:0]        c_root  [0:NC];

  logic                 back_valid;
  ihc_res_t             back_res;
  logic                 out_v_q, skid_v_q;
  ihc_res_t             out_q, skid_q;
  logic                 take;

  // Stall is registered: the skid register absorbs the one transfer in flight.
  assign en          = !skid_v_q;
  assign pix_i.ready = en;

  ihc_front #(.CHANNEL_BITS(CHANNEL_BITS)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (pix_i.valid),
    .red_i   (pix_i.red),
    .green_i (pix_i.green),
    .blue_i  (pix_i.blue),
    .ctl_o   (c_ctl[0]),
    .inten_o (c_inten[0]),
    .x_o     (c_x[0]),
    .y_o     (c_y[0]),
    .z_o     (c_z[0]),
    .rad_o   (c_rad[0])
  );

  assign c_rem[0]  = '0;
  assign c_root[0] = '0;

  generate
    for (genvar i = 0; i < NC; i++) begin : g_cell
      ihc_cell #(.CHANNEL_BITS(CHANNEL_BITS), .IDX(i)) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .en_i    (en),
        .ctl_i   (c_ctl[i]),
        .inten_i (c_inten[i]),
        .x_i     (c_x[i]),
        .y_i     (c_y[i]),
        .z_i     (c_z[i]),
        .rad_i   (c_rad[i]),
        .rem_i   (c_rem[i]),
        .root_i  (c_root[i]),
        .ctl_o   (c_ctl[i+1]),
        .inten_o (c_inten[i+1]),
        .x_o     (c_x[i+1]),
        .y_o     (c_y[i+1]),
        .z_o     (c_z[i+1]),
        .rad_o   (c_rad[i+1]),
        .rem_o   (c_rem[i+1]),
        .root_o  (c_root[i+1])
      );
    end
  endgenerate

  ihc_back #(.CHANNEL_BITS(CHANNEL_BITS)) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .ctl_i   (c_ctl[NC]),
    .inten_i (c_inten[NC]),
    .z_i     (c_z[NC]),
    .rem_i   (c_rem[NC]),
    .root_i  (c_root[NC]),
    .valid_o (back_valid),
    .res_o   (back_res)
  );

  assign take = res_o.ready || !out_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (take) begin
      out_v_q  <= skid_v_q || (en && back_valid);
      skid_v_q <= 1'b0;
    end else if (en && back_valid) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= skid_v_q ? skid_q : back_res;
    end else if (en && back_valid) begin
      skid_q <= back_res;
    end
  end

  assign res_o.valid         = out_v_q;
  assign res_o.intensity     = out_q.intensity;
  assign res_o.chroma        = out_q.chroma;
  assign res_o.hue           = out_q.hue;
  assign res_o.hue_undefined = out_q.hue_undefined;

`ifndef SYNTHESIS
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid register holds a result while the output register is empty");

  a_skid_fill_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_v_q && !res_o.ready))
    else $error("skid register filled without a stalled output");

  a_gray_hue_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.hue_undefined) |-> (res_o.hue == '0))
    else $error("gray pixel produced a nonzero hue");

  a_hue_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.hue < HUE_STEPS))
    else $error("hue outside a full turn");
`endif

endmodule

### src/ihc_front.sv
// Front pipeline: differences, squares, intensity and the CORDIC/root start values.
`timescale 1ns / 1ps

module ihc_front #(
  parameter int unsigned CHANNEL_BITS = ihc_pkg::CHANNEL_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic [CHANNEL_BITS-1:0]             red_i,
  input  logic [CHANNEL_BITS-1:0]             green_i,
  input  logic [CHANNEL_BITS-1:0]             blue_i,
  output ihc_pkg::ihc_ctl_t                   ctl_o,
  output logic [ihc_pkg::INTEN_W-1:0]         inten_o,
  output logic signed [CHANNEL_BITS+33:0]     x_o,
  output logic signed [CHANNEL_BITS+33:0]     y_o,
  output logic signed [ihc_pkg::ZW-1:0]       z_o,
  output logic [2*CHANNEL_BITS+15:0]          rad_o
);
  import ihc_pkg::*;

  localparam int unsigned CB = CHANNEL_BITS;
  localparam int unsigned XW = CB + 34;
  localparam int unsigned QW = CB + 9;
  localparam int unsigned EW = (QW > INTEN_W) ? QW : INTEN_W;

  // Stage 1
  ihc_ctl_t               ctl1_q;
  logic signed [CB+1:0]   x1_q, x1_d;
  logic signed [CB:0]     a1_q, a1_d, d1_q, d1_d, c1_q, c1_d;
  logic [CB+1:0]          sum1_q, sum1_d;

  // Stage 2
  ihc_ctl_t               ctl2_q;
  logic                   neg2_q;
  logic [CB:0]            xa2_q, xa2_d;
  logic signed [CB:0]     yd2_q, yd2_d;
  logic [2*CB-1:0]        sqa2_q, sqb2_q, sqc2_q;
  logic [QW-1:0]          q2_q, q2_d;
  logic signed [CB+1:0]   xabs;
  logic signed [2*CB+1:0] sqa, sqb, sqc;
  logic [CB+9:0]          nq;
  logic [CB+41:0]         qprod;

  // Stage 3
  logic signed [CB+32:0]  ymul;
  logic [2*CB+1:0]        ssum;
  logic [EW-1:0]          q_ext;

  assign x1_d   = $signed({1'b0, red_i, 1'b0}) - $signed({2'b00, green_i})
                - $signed({2'b00, blue_i});
  assign a1_d   = $signed({1'b0, red_i})   - $signed({1'b0, green_i});
  assign d1_d   = $signed({1'b0, green_i}) - $signed({1'b0, blue_i});
  assign c1_d   = $signed({1'b0, blue_i})  - $signed({1'b0, red_i});
  assign sum1_d = {2'b00, red_i} + {2'b00, green_i} + {2'b00, blue_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
    end else if (en_i) begin
      ctl1_q.valid <= valid_i;
      ctl1_q.gray  <= (red_i == green_i) && (green_i == blue_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x1_q   <= x1_d;
      a1_q   <= a1_d;
      d1_q   <= d1_d;
      c1_q   <= c1_d;
      sum1_q <= sum1_d;
    end
  end

  // A negative x folds the vector into the right half plane; the angle starts at 180.
  assign xabs  = x1_q[CB+1] ? -x1_q : x1_q;
  assign xa2_d = xabs[CB:0];
  assign yd2_d = x1_q[CB+1] ? -d1_q : d1_q;
  assign sqa   = a1_q * a1_q;
  assign sqb   = d1_q * d1_q;
  assign sqc   = c1_q * c1_q;
  assign nq    = {sum1_q, 8'h01};
  assign qprod = (CB+42)'(nq) * (CB+42)'(RECIP_3);
  assign q2_d  = qprod[CB+41:RECIP_3_SHIFT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl2_q <= '0;
    end else if (en_i) begin
      ctl2_q <= ctl1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg2_q <= x1_q[CB+1];
      xa2_q  <= xa2_d;
      yd2_q  <= yd2_d;
      sqa2_q <= sqa[2*CB-1:0];
      sqb2_q <= sqb[2*CB-1:0];
      sqc2_q <= sqc[2*CB-1:0];
      q2_q   <= q2_d;
    end
  end

  assign ymul  = (CB+33)'(yd2_q) * (CB+33)'(SQRT3_Q30);
  assign ssum  = {2'b00, sqa2_q} + {2'b00, sqb2_q} + {2'b00, sqc2_q};
  assign q_ext = EW'(q2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_o <= '0;
    end else if (en_i) begin
      ctl_o <= ctl2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_o     <= XW'({xa2_q, {Q_FRAC{1'b0}}});
      y_o     <= XW'(ymul);
      z_o     <= neg2_q ? Z_180 : '0;
      // The squared-difference sum never exceeds twice the largest code squared.
      rad_o   <= {ssum[2*CB:0], {RAD_SHIFT{1'b0}}};
      inten_o <= (q_ext > EW'({INTEN_W{1'b1}})) ? {INTEN_W{1'b1}} : q_ext[INTEN_W-1:0];
    end
  end

endmodule

### src/ihc_cell.sv
// One cell of the chain: a CORDIC vectoring step and, while IDX < CHANNEL_BITS+8, a square-root digit step.
`timescale 1ns / 1ps

module ihc_cell #(
  parameter int unsigned CHANNEL_BITS = ihc_pkg::CHANNEL_BITS_DEF,
  parameter int unsigned IDX          = 0
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  ihc_pkg::ihc_ctl_t               ctl_i,
  input  logic [ihc_pkg::INTEN_W-1:0]     inten_i,
  input  logic signed [CHANNEL_BITS+33:0] x_i,
  input  logic signed [CHANNEL_BITS+33:0] y_i,
  input  logic signed [ihc_pkg::ZW-1:0]   z_i,
  input  logic [2*CHANNEL_BITS+15:0]      rad_i,
  input  logic [CHANNEL_BITS+8:0]         rem_i,
  input  logic [CHANNEL_BITS+7:0]         root_i,
  output ihc_pkg::ihc_ctl_t               ctl_o,
  output logic [ihc_pkg::INTEN_W-1:0]     inten_o,
  output logic signed [CHANNEL_BITS+33:0] x_o,
  output logic signed [CHANNEL_BITS+33:0] y_o,
  output logic signed [ihc_pkg::ZW-1:0]   z_o,
  output logic [2*CHANNEL_BITS+15:0]      rad_o,
  output logic [CHANNEL_BITS+8:0]         rem_o,
  output logic [CHANNEL_BITS+7:0]         root_o
);
  import ihc_pkg::*;

  localparam int unsigned XW = CHANNEL_BITS + 34;
  localparam int unsigned RB = CHANNEL_BITS + 8;
  localparam int unsigned XB = 2 * RB;
  localparam logic signed [ZW-1:0] ATAN_I = atan_ndeg(IDX);

  logic signed [XW-1:0] xs, ys, x_d, y_d;
  logic signed [ZW-1:0] z_d;
  logic                 rot_neg;
  logic [XB-1:0]        rad_d;
  logic [RB:0]          rem_d;
  logic [RB-1:0]        root_d;

  assign xs      = x_i >>> IDX;
  assign ys      = y_i >>> IDX;
  // Rotate clockwise only while y is strictly positive.
  assign rot_neg = !y_i[XW-1] && (y_i != '0);
  assign x_d     = rot_neg ? x_i + ys : x_i - ys;
  assign y_d     = rot_neg ? y_i - xs : y_i + xs;
  assign z_d     = rot_neg ? z_i + ATAN_I : z_i - ATAN_I;

  generate
    if (IDX < RB) begin : g_root
      logic [RB+2:0] rem_t, trial;
      logic          ge;
      logic [RB+2:0] rem_s;

      assign rem_t  = {rem_i, rad_i[XB-1:XB-2]};
      assign trial  = {1'b0, root_i, 2'b01};
      assign ge     = rem_t >= trial;
      assign rem_s  = ge ? rem_t - trial : rem_t;
      // The partial remainder stays at most twice the partial root.
      assign rem_d  = rem_s[RB:0];
      assign root_d = {root_i[RB-2:0], ge};
      assign rad_d  = {rad_i[XB-3:0], 2'b00};
    end else begin : g_pass
      assign rem_d  = rem_i;
      assign root_d = root_i;
      assign rad_d  = rad_i;
    end
  endgenerate

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_o <= '0;
    end else if (en_i) begin
      ctl_o <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      inten_o <= inten_i;
      x_o     <= x_d;
      y_o     <= y_d;
      z_o     <= z_d;
      rad_o   <= rad_d;
      rem_o   <= rem_d;
      root_o  <= root_d;
    end
  end

endmodule

### src/ihc_back.sv
// Back pipeline: chroma rounding and quantization of the angle to 1/64 degree.
`timescale 1ns / 1ps

module ihc_back #(
  parameter int unsigned CHANNEL_BITS = ihc_pkg::CHANNEL_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  ihc_pkg::ihc_ctl_t             ctl_i,
  input  logic [ihc_pkg::INTEN_W-1:0]   inten_i,
  input  logic signed [ihc_pkg::ZW-1:0] z_i,
  input  logic [CHANNEL_BITS+8:0]       rem_i,
  input  logic [CHANNEL_BITS+7:0]       root_i,
  output logic                          valid_o,
  output ihc_pkg::ihc_res_t             res_o
);
  import ihc_pkg::*;

  localparam int unsigned RB = CHANNEL_BITS + 8;
  localparam int unsigned EW = (RB + 1 > CHROMA_W) ? RB + 1 : CHROMA_W;
  localparam int unsigned PW = BW - HUE_PRE_SHIFT + HUE_RECIP_W;

  ihc_ctl_t              ctl1_q, ctl2_q, ctl3_q;
  logic [INTEN_W-1:0]    inten1_q, inten2_q, inten3_q;
  logic [CHROMA_W-1:0]   chroma1_q, chroma2_q, chroma3_q;
  logic [BW-1:0]         b1_q, b2_q, b3_q;
  logic [HUE_W-1:0]      qe2_q, qe3_q;
  logic [BW-1:0]         p3_q;

  logic [RB:0]           rt;
  logic [EW-1:0]         rt_ext;
  logic signed [ZW-1:0]  tz;
  logic [PW-1:0]         qprod;
  logic [BW-1:0]         rmd;
  logic [HUE_W-1:0]      n;

  // Round to nearest: step up when the remainder exceeds the floor root.
  assign rt     = {1'b0, root_i} + (RB+1)'(rem_i > {1'b0, root_i});
  assign rt_ext = EW'(rt);
  // Wrap a negative angle by a full turn and add half a step in the same add.
  assign tz     = z_i + (z_i[ZW-1] ? Z_WRAP_BIAS : Z_ROUND);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q  <= '0;
      ctl2_q  <= '0;
      ctl3_q  <= '0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      ctl1_q  <= ctl_i;
      ctl2_q  <= ctl1_q;
      ctl3_q  <= ctl2_q;
      valid_o <= ctl3_q.valid;
    end
  end

  assign qprod = PW'(b1_q[BW-1:HUE_PRE_SHIFT]) * PW'(HUE_RECIP);
  assign rmd   = b3_q - p3_q;
  // The estimate is the true quotient or one below it.
  assign n     = qe3_q + HUE_W'(rmd >= BW'(HUE_DIV));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      inten1_q  <= inten_i;
      chroma1_q <= (rt_ext > EW'({CHROMA_W{1'b1}})) ? {CHROMA_W{1'b1}}
                                                     : rt_ext[CHROMA_W-1:0];
      b1_q      <= tz[BW+T_SHIFT-1:T_SHIFT];

      inten2_q  <= inten1_q;
      chroma2_q <= chroma1_q;
      b2_q      <= b1_q;
      qe2_q     <= qprod[HUE_RECIP_SHIFT+HUE_W-1:HUE_RECIP_SHIFT];

      inten3_q  <= inten2_q;
      chroma3_q <= chroma2_q;
      b3_q      <= b2_q;
      qe3_q     <= qe2_q;
      p3_q      <= BW'(qe2_q) * BW'(HUE_DIV);

      res_o.intensity     <= inten3_q;
      res_o.chroma        <= chroma3_q;
      res_o.hue           <= (ctl3_q.gray || (n == HUE_STEPS)) ? '0 : n;
      res_o.hue_undefined <= ctl3_q.gray;
    end
  end

endmodule

### bench/tb_rgb_to_intensity_chroma_hue_core.sv
// Self-checking testbench for the RGB to intensity/chroma/hue converter.
`timescale 1ns / 1ps

module tb_rgb_to_intensity_chroma_hue_core;
  import ihc_pkg::*;

  localparam int unsigned CH_BITS        = CHANNEL_BITS_DEF;
  localparam int          CH_MAX         = (1 << CH_BITS) - 1;
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          HOLD_OFF       = 300;
  localparam int          SETTLE_CYCLES  = 60;

  localparam longint Q30_UNIT    = 64'sd1073741824;
  localparam longint ROOT3_Q30   = 64'sd1859775393;
  localparam longint HALF_TURN   = 64'sd180000000000;
  localparam longint FULL_TURN   = 64'sd360000000000;
  localparam longint NANO_DEG    = 64'sd1000000000;
  localparam longint STEPS_PER_TURN = 64'sd23040;

  // Arctangent of 2^-i, in units of 1e-9 degree.
  localparam longint ARCTAN_STEP [32] = '{
    64'sd45000000000, 64'sd26565051177, 64'sd14036243468, 64'sd7125016349,
    64'sd3576334375, 64'sd1789910608, 64'sd895173710, 64'sd447614171,
    64'sd223810500, 64'sd111905677, 64'sd55952892, 64'sd27976453,
    64'sd13988227, 64'sd6994114, 64'sd3497057, 64'sd1748528,
    64'sd874264, 64'sd437132, 64'sd218566, 64'sd109283,
    64'sd54642, 64'sd27321, 64'sd13660, 64'sd6830,
    64'sd3415, 64'sd1708, 64'sd854, 64'sd427,
    64'sd213, 64'sd107, 64'sd53, 64'sd27
  };

  logic clk_i;
  logic rst_ni;

  ihc_pix_if #(.CHANNEL_BITS(CH_BITS)) pix_if ();
  ihc_res_if res_if ();

  rgb_to_intensity_chroma_hue_core #(.CHANNEL_BITS(CH_BITS)) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .pix_i (pix_if),
    .res_o (res_if)
  );

  ihc_res_t pending_hci[$];
  int       fail_count;
  bit       idle_on;
  int       hold_cycles;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Bitwise integer square root, rounding down.
  function automatic logic [63:0] int_sqrt(input logic [63:0] val);
    logic [63:0] rem;
    logic [63:0] acc;
    logic [63:0] probe;
    rem   = val;
    acc   = '0;
    probe = 64'd1 << 62;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= acc + probe) begin
        rem = rem - (acc + probe);
        acc = (acc >> 1) + probe;
      end else begin
        acc = acc >> 1;
      end
      probe = probe >> 2;
    end
    return acc;
  endfunction

  // Vectoring CORDIC on (2r-g-b, sqrt3*(g-b)); the angle comes back in 1/64 degree.
  function automatic logic [HUE_W-1:0] cordic_hue(input longint xin, input longint din);
    longint xa;
    longint ya;
    longint za;
    longint xs;
    longint ys;
    longint ang;
    longint steps;
    int     i;
    xa = xin * Q30_UNIT;
    ya = din * ROOT3_Q30;
    za = 0;
    if (xa < 0) begin
      xa = -xa;
      ya = -ya;
      za = HALF_TURN;
    end
    for (i = 0; i < 32; i++) begin
      xs = xa >>> i;
      ys = ya >>> i;
      if (ya > 0) begin
        xa = xa + ys;
        ya = ya - xs;
        za = za + ARCTAN_STEP[i];
      end else begin
        xa = xa - ys;
        ya = ya + xs;
        za = za - ARCTAN_STEP[i];
      end
    end
    ang = za % FULL_TURN;
    if (ang < 0) ang = ang + FULL_TURN;
    steps = (ang * 64 + NANO_DEG / 2) / NANO_DEG;
    if (steps >= STEPS_PER_TURN) steps = steps - STEPS_PER_TURN;
    return steps[HUE_W-1:0];
  endfunction

  function automatic ihc_res_t predict_hci(input logic [CH_BITS-1:0] r,
                                           input logic [CH_BITS-1:0] g,
                                           input logic [CH_BITS-1:0] b);
    longint      ri;
    longint      gi;
    longint      bi;
    longint      mean_q8;
    longint      sq_sum;
    logic [63:0] rad;
    logic [63:0] root;
    ihc_res_t    res;
    ri = longint'(r);
    gi = longint'(g);
    bi = longint'(b);
    mean_q8 = ((ri + gi + bi) * 256 + 1) / 3;
    res.intensity = (mean_q8 > 65535) ? 16'hFFFF : mean_q8[INTEN_W-1:0];
    sq_sum = (ri - gi) * (ri - gi) + (gi - bi) * (gi - bi) + (bi - ri) * (bi - ri);
    rad  = sq_sum * 32768;
    root = int_sqrt(rad);
    if (rad > root * root + root) root = root + 1;
    res.chroma = (root > 65535) ? 16'hFFFF : root[CHROMA_W-1:0];
    if (ri == gi && gi == bi) begin
      res.hue           = '0;
      res.hue_undefined = 1'b1;
    end else begin
      res.hue           = cordic_hue(2 * ri - gi - bi, gi - bi);
      res.hue_undefined = 1'b0;
    end
    return res;
  endfunction

  function automatic int pick_gap();
    if (idle_on && $urandom_range(0, 7) == 0) return $urandom_range(1, 17);
    return 0;
  endfunction

  // Offers one pixel and returns at the edge where it was transferred.
  task automatic send_pixel(input int r, input int g, input int b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      pix_if.valid <= 1'b0;
      pix_if.red   <= CH_BITS'($urandom_range(0, CH_MAX));
      pix_if.green <= CH_BITS'($urandom_range(0, CH_MAX));
      pix_if.blue  <= CH_BITS'($urandom_range(0, CH_MAX));
      repeat (gap) @(posedge clk_i);
    end
    pix_if.valid <= 1'b1;
    pix_if.red   <= CH_BITS'(r);
    pix_if.green <= CH_BITS'(g);
    pix_if.blue  <= CH_BITS'(b);
    do @(posedge clk_i); while (!pix_if.ready);
    pending_hci.push_back(predict_hci(CH_BITS'(r), CH_BITS'(g), CH_BITS'(b)));
  endtask

  function automatic int clamp_code(input int v);
    if (v < 0) return 0;
    if (v > CH_MAX) return CH_MAX;
    return v;
  endfunction

  // Mixes uniform pixels with gray, green-equals-blue, near-gray and corner pixels.
  task automatic send_random_pixel();
    int kind;
    int base;
    int r;
    int g;
    int b;
    kind = $urandom_range(0, 9);
    base = $urandom_range(0, CH_MAX);
    r = $urandom_range(0, CH_MAX);
    g = $urandom_range(0, CH_MAX);
    b = $urandom_range(0, CH_MAX);
    case (kind)
      0: begin
        r = base;
        g = base;
        b = base;
      end
      1: b = g;
      2: begin
        r = clamp_code(base + $urandom_range(0, 4) - 2);
        g = clamp_code(base + $urandom_range(0, 4) - 2);
        b = clamp_code(base + $urandom_range(0, 4) - 2);
      end
      3: begin
        r = $urandom_range(0, 1) ? CH_MAX - $urandom_range(0, 1) : $urandom_range(0, 1);
        g = $urandom_range(0, 1) ? CH_MAX - $urandom_range(0, 1) : $urandom_range(0, 1);
        b = $urandom_range(0, 1) ? CH_MAX - $urandom_range(0, 1) : $urandom_range(0, 1);
      end
      default: ;
    endcase
    send_pixel(r, g, b);
  endtask

  task automatic wait_results_drained();
    pix_if.valid <= 1'b0;
    while (pending_hci.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_primary_and_corner_pixels();
    send_pixel(0, 0, 0);
    send_pixel(CH_MAX, CH_MAX, CH_MAX);
    send_pixel(128, 128, 128);
    send_pixel(CH_MAX, 0, 0);
    send_pixel(0, CH_MAX, 0);
    send_pixel(0, 0, CH_MAX);
    send_pixel(CH_MAX, CH_MAX, 0);
    send_pixel(0, CH_MAX, CH_MAX);
    send_pixel(CH_MAX, 0, CH_MAX);
    // Green equals blue: red above gives zero hue, red below gives half a turn.
    send_pixel(200, 10, 10);
    send_pixel(10, 200, 200);
    send_pixel(1, 0, 0);
    send_pixel(0, 1, 1);
    send_pixel(CH_MAX - 1, CH_MAX, CH_MAX);
    // Hue just short of a full turn.
    send_pixel(CH_MAX, 0, 1);
    send_pixel(CH_MAX, 1, 0);
    send_pixel(170, 85, 170);
    send_pixel(85, 170, 85);
    send_pixel(170, 85, 240);
    send_pixel(85, 170, 15);
  endtask

  // Alternates stretches with and without idling on both sides.
  task automatic test_random_pixels(input int count);
    int n;
    for (n = 0; n < count; n++) begin
      if (n % 175 == 0) idle_on = ((n / 175) % 2 == 0);
      send_random_pixel();
    end
    idle_on = 1'b1;
  endtask

  // The receiver holds off while pixels keep coming, so the pipeline fills and stalls.
  task automatic test_output_backpressure(input int count);
    int n;
    idle_on     = 1'b0;
    hold_cycles = HOLD_OFF;
    for (n = 0; n < count; n++) send_random_pixel();
    idle_on = 1'b1;
    wait_results_drained();
    for (n = 0; n < 40; n++) send_random_pixel();
  endtask

  task automatic test_full_rate_tail(input int count);
    int n;
    idle_on = 1'b0;
    for (n = 0; n < count; n++) send_random_pixel();
  endtask

  // Receiver: random stall bursts, plus the long hold-off on request.
  initial begin
    int stall_left;
    stall_left = 0;
    res_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        res_if.ready <= 1'b0;
        hold_cycles--;
      end else if (stall_left > 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        res_if.ready <= 1'b0;
        stall_left = $urandom_range(1, 17) - 1;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Each result transfer is matched against the oldest prediction.
  always @(posedge clk_i) begin
    ihc_res_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_hci.size() == 0) begin
        $error("result with no pixel pending: intensity %0d chroma %0d hue %0d",
               res_if.intensity, res_if.chroma, res_if.hue);
        fail_count++;
      end else begin
        want = pending_hci.pop_front();
        if (res_if.intensity !== want.intensity) begin
          $error("intensity: expected %0d, got %0d", want.intensity, res_if.intensity);
          fail_count++;
        end
        if (res_if.chroma !== want.chroma) begin
          $error("chroma: expected %0d, got %0d", want.chroma, res_if.chroma);
          fail_count++;
        end
        if (res_if.hue !== want.hue) begin
          $error("hue: expected %0d, got %0d", want.hue, res_if.hue);
          fail_count++;
        end
        if (res_if.hue_undefined !== want.hue_undefined) begin
          $error("hue_undefined: expected %0d, got %0d",
                 want.hue_undefined, res_if.hue_undefined);
          fail_count++;
        end
      end
    end
  end

  // Ends the run when no transfer happens on either side for too long.
  initial begin
    int quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    fail_count   = 0;
    idle_on      = 1'b1;
    hold_cycles  = 0;
    pix_if.valid <= 1'b0;
    pix_if.red   <= '0;
    pix_if.green <= '0;
    pix_if.blue  <= '0;
    rst_ni       <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_primary_and_corner_pixels();
    test_random_pixels(1400);
    test_output_backpressure(120);
    test_full_rate_tail(370);

    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
